[design/assert_macros.svh]
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/mlr_pkg.sv]
`timescale 1ns / 1ps
package mlr_pkg;

    // Request opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Extra headroom bits of the decision value over the coordinate width
    localparam int DEC_EXTRA = 4;

    // Step directions, each -1, 0 or +1
    typedef struct packed {
        logic signed [1:0] neg_dx;
        logic signed [1:0] neg_dy;
        logic signed [1:0] pos_dx;
        logic signed [1:0] pos_dy;
    } t_dirs;

endpackage

[design/mlr_setup.sv]
`timescale 1ns / 1ps
module mlr_setup #(
    parameter int CB = 12
) (
    input  logic signed [CB-1:0]                i_x0,
    input  logic signed [CB-1:0]                i_y0,
    input  logic signed [CB-1:0]                i_x1,
    input  logic signed [CB-1:0]                i_y1,
    output logic signed [CB-1:0]                o_x,
    output logic signed [CB-1:0]                o_y,
    output logic signed [CB+mlr_pkg::DEC_EXTRA-1:0] o_dec,
    output logic signed [CB+mlr_pkg::DEC_EXTRA-1:0] o_inc_neg,
    output logic signed [CB+mlr_pkg::DEC_EXTRA-1:0] o_inc_pos,
    output mlr_pkg::t_dirs                      o_dirs,
    output logic        [CB-1:0]                o_steps
);
    import mlr_pkg::*;

    localparam int DB = CB + DEC_EXTRA;

    logic signed [DB-1:0] x0_w, y0_w, x1_w, y1_w;
    logic signed [DB-1:0] ddx, ddy, adx, ady, a, b, a2, b2;
    logic                 dx_neg, dx_zero, dy_neg, dy_zero;
    logic                 falling, swap, major_x;

    // Widen endpoints to decision width
    assign x0_w = {{(DB-CB){i_x0[CB-1]}}, i_x0};
    assign y0_w = {{(DB-CB){i_y0[CB-1]}}, i_y0};
    assign x1_w = {{(DB-CB){i_x1[CB-1]}}, i_x1};
    assign y1_w = {{(DB-CB){i_y1[CB-1]}}, i_y1};

    assign ddx     = x1_w - x0_w;
    assign ddy     = y1_w - y0_w;
    assign dx_neg  = ddx[DB-1];
    assign dy_neg  = ddy[DB-1];
    assign dx_zero = (ddx == '0);
    assign dy_zero = (ddy == '0);
    assign adx     = dx_neg ? -ddx : ddx;
    assign ady     = dy_neg ? -ddy : ddy;
    assign major_x = ($unsigned(adx) >= $unsigned(ady));

    // Classify direction and pick the starting end
    assign falling = (!dx_neg && dy_neg) || ((dx_neg || dx_zero) && !dy_neg && !dy_zero);
    assign swap    = falling ? ((dx_neg || dx_zero) && !dy_neg && !dy_zero)
                             : ((dx_neg || dx_zero) && (dy_neg || dy_zero));

    assign a  = swap ? ddy : -ddy;
    assign b  = swap ? -ddx : ddx;
    assign a2 = a <<< 1;
    assign b2 = b <<< 1;

    assign o_x = swap ? i_x1 : i_x0;
    assign o_y = swap ? i_y1 : i_y0;

    // Set decision, increments and step directions per octant class
    always_comb begin
        case ({falling, major_x})
            2'b11: begin
                o_steps   = adx[CB-1:0];
                o_dirs    = '{2'sd1, 2'sd0, 2'sd1, -2'sd1};
                o_dec     = a2 - b;
                o_inc_neg = a2;
                o_inc_pos = a2 - b2;
            end
            2'b10: begin
                o_steps   = ady[CB-1:0];
                o_dirs    = '{2'sd1, -2'sd1, 2'sd0, -2'sd1};
                o_dec     = a - b2;
                o_inc_neg = a2 - b2;
                o_inc_pos = -b2;
            end
            2'b01: begin
                o_steps   = adx[CB-1:0];
                o_dirs    = '{2'sd1, 2'sd1, 2'sd1, 2'sd0};
                o_dec     = a2 + b;
                o_inc_neg = a2 + b2;
                o_inc_pos = a2;
            end
            default: begin
                o_steps   = ady[CB-1:0];
                o_dirs    = '{2'sd0, 2'sd1, 2'sd1, 2'sd1};
                o_dec     = b2 + a;
                o_inc_neg = b2;
                o_inc_pos = a2 + b2;
            end
        endcase
    end

endmodule

[design/mlr_step.sv]
`timescale 1ns / 1ps
module mlr_step #(
    parameter int CB = 12
) (
    input  logic signed [CB-1:0]                    i_cur_x,
    input  logic signed [CB-1:0]                    i_cur_y,
    input  logic signed [CB+mlr_pkg::DEC_EXTRA-1:0] i_dec,
    input  logic signed [CB+mlr_pkg::DEC_EXTRA-1:0] i_inc_neg,
    input  logic signed [CB+mlr_pkg::DEC_EXTRA-1:0] i_inc_pos,
    input  mlr_pkg::t_dirs                          i_dirs,
    input  logic        [CB-1:0]                    i_steps,
    output logic signed [CB-1:0]                    o_x,
    output logic signed [CB-1:0]                    o_y,
    output logic signed [CB+mlr_pkg::DEC_EXTRA-1:0] o_dec,
    output logic        [CB-1:0]                    o_steps,
    output logic                                    o_done
);
    import mlr_pkg::*;

    logic              take_neg;
    logic signed [1:0] dx, dy;

    // Select the step by the sign of the decision; a tie takes the nonnegative step
    assign take_neg = i_dec[CB+DEC_EXTRA-1];
    assign dx       = take_neg ? i_dirs.neg_dx : i_dirs.pos_dx;
    assign dy       = take_neg ? i_dirs.neg_dy : i_dirs.pos_dy;

    // Advance position, decision and step count
    assign o_x     = i_cur_x + {{(CB-2){dx[1]}}, dx};
    assign o_y     = i_cur_y + {{(CB-2){dy[1]}}, dy};
    assign o_dec   = i_dec + (take_neg ? i_inc_neg : i_inc_pos);
    assign o_steps = i_steps - {{(CB-1){1'b0}}, 1'b1};
    assign o_done  = (o_steps == '0);

endmodule

[design/midpoint_line_rasterizer.sv]
`timescale 1ns / 1ps
// Channel  Direction  Handshake                   Payload
// input    in         i_in_valid / o_in_ready     i_opcode, i_x_start, i_y_start, i_x_end, i_y_end
// output   out        o_out_valid / i_out_ready   o_pixel_x, o_pixel_y, o_last_pixel
//
// One request per cycle while no held result stalls it; a taken request passes the
// input register, then setup or step logic into the line state and result register.
// Reset (synchronous, active low) empties both registers and drops any active line.
// A held result stalls the input register; o_in_ready follows i_out_ready when both
// registers are full. A step request with no active line is consumed without a result.
`include "assert_macros.svh"
module midpoint_line_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_opcode,
    input  logic signed [COORD_BITS-1:0] i_x_start,
    input  logic signed [COORD_BITS-1:0] i_y_start,
    input  logic signed [COORD_BITS-1:0] i_x_end,
    input  logic signed [COORD_BITS-1:0] i_y_end,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic                         o_last_pixel
);
    import mlr_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int DB = COORD_BITS + DEC_EXTRA;

    // Input register
    logic                 r_in_valid;
    logic                 r_in_op;
    logic signed [CB-1:0] r_in_x0, r_in_y0, r_in_x1, r_in_y1;

    // Line state
    logic signed [CB-1:0] r_cur_x, r_cur_y;
    logic signed [DB-1:0] r_dec, r_inc_neg, r_inc_pos;
    t_dirs                r_dirs;
    logic        [CB-1:0] r_steps;
    logic                 r_active;

    // Result register
    logic                 r_out_valid;
    logic signed [CB-1:0] r_pix_x, r_pix_y;
    logic                 r_last;

    logic                 out_free, proc, is_start, is_step;
    logic signed [CB-1:0] su_x, su_y, st_x, st_y;
    logic signed [DB-1:0] su_dec, su_inc_neg, su_inc_pos, st_dec;
    t_dirs                su_dirs;
    logic        [CB-1:0] su_steps, st_steps;
    logic                 st_done;
    logic                 last_ok;

    assign out_free   = !r_out_valid || i_out_ready;
    assign proc       = r_in_valid && out_free;
    assign is_start   = proc && (r_in_op == OP_START);
    assign is_step    = proc && (r_in_op == OP_STEP) && r_active;
    assign o_in_ready = !r_in_valid || out_free;

    mlr_setup #(.CB(CB)) u_setup (
        .i_x0      (r_in_x0),
        .i_y0      (r_in_y0),
        .i_x1      (r_in_x1),
        .i_y1      (r_in_y1),
        .o_x       (su_x),
        .o_y       (su_y),
        .o_dec     (su_dec),
        .o_inc_neg (su_inc_neg),
        .o_inc_pos (su_inc_pos),
        .o_dirs    (su_dirs),
        .o_steps   (su_steps)
    );

    mlr_step #(.CB(CB)) u_step (
        .i_cur_x   (r_cur_x),
        .i_cur_y   (r_cur_y),
        .i_dec     (r_dec),
        .i_inc_neg (r_inc_neg),
        .i_inc_pos (r_inc_pos),
        .i_dirs    (r_dirs),
        .i_steps   (r_steps),
        .o_x       (st_x),
        .o_y       (st_y),
        .o_dec     (st_dec),
        .o_steps   (st_steps),
        .o_done    (st_done)
    );

    // Capture a request whenever the input register frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_op <= i_opcode;
            r_in_x0 <= i_x_start;
            r_in_y0 <= i_y_start;
            r_in_x1 <= i_x_end;
            r_in_y1 <= i_y_end;
        end
    end

    // Load a new line on start, advance it on step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_dec     <= '0;
            r_inc_neg <= '0;
            r_inc_pos <= '0;
            r_dirs    <= '0;
            r_steps   <= '0;
            r_active  <= 1'b0;
        end else if (is_start) begin
            r_cur_x   <= su_x;
            r_cur_y   <= su_y;
            r_dec     <= su_dec;
            r_inc_neg <= su_inc_neg;
            r_inc_pos <= su_inc_pos;
            r_dirs    <= su_dirs;
            r_steps   <= su_steps;
            r_active  <= (su_steps != '0);
        end else if (is_step) begin
            r_cur_x   <= st_x;
            r_cur_y   <= st_y;
            r_dec     <= st_dec;
            r_steps   <= st_steps;
            r_active  <= !st_done;
        end
    end

    // Hold the pixel until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (is_start || is_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (is_start) begin
            r_pix_x <= su_x;
            r_pix_y <= su_y;
            r_last  <= (su_steps == '0);
        end else if (is_step) begin
            r_pix_x <= st_x;
            r_pix_y <= st_y;
            r_last  <= st_done;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_x    = r_pix_x;
    assign o_pixel_y    = r_pix_y;
    assign o_last_pixel = r_last;

    // Pixel shown and its last flag agrees with the line state
    assign last_ok = o_out_valid && (o_last_pixel == !r_active);

    `ASSERT_IMPLY(a_active_steps, i_clk, i_rst_n, r_active, r_steps != '0, "active, no steps")
    `ASSERT_NEXT(a_start_last, i_clk, i_rst_n, is_start, last_ok, "start pixel last flag wrong")
    `ASSERT_NEXT(a_step_last, i_clk, i_rst_n, is_step, last_ok, "step pixel last flag wrong")

endmodule

[dv/midpoint_line_checker.sv]
`timescale 1ns / 1ps
module midpoint_line_checker
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_opcode,
    input  logic signed [COORD_BITS-1:0] i_x_start,
    input  logic signed [COORD_BITS-1:0] i_y_start,
    input  logic signed [COORD_BITS-1:0] i_x_end,
    input  logic signed [COORD_BITS-1:0] i_y_end,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic signed [COORD_BITS-1:0] i_pixel_x,
    input  logic signed [COORD_BITS-1:0] i_pixel_y,
    input  logic                         i_last_pixel,
    output int                           o_error_count,
    output int                           o_pending_count
);

    localparam int DEC_BITS = COORD_BITS + DEC_EXTRA;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DEC_BITS-1:0]   dec_t;
    typedef logic [COORD_BITS-1:0]        count_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last_pixel;
    } pixel_t;

    // Shadow copy of the line walker
    coord_t cur_x;
    coord_t cur_y;
    dec_t   decision;
    dec_t   inc_neg;
    dec_t   inc_pos;
    t_dirs  dirs;
    count_t steps_left;
    logic   line_active;

    // Pixels predicted but not yet seen on the output channel
    pixel_t expected_pixels[$];

    function automatic t_dirs make_dirs(input int ndx, input int ndy,
                                        input int pdx, input int pdy);
        t_dirs d;
        d.neg_dx = 2'(ndx);
        d.neg_dy = 2'(ndy);
        d.pos_dx = 2'(pdx);
        d.pos_dy = 2'(pdy);
        return d;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        o_error_count++;
    endtask

    // Pick the octant and starting end, load decision, increments and directions
    task automatic begin_line(input coord_t x0, input coord_t y0,
                              input coord_t x1, input coord_t y1);
        int ddx, ddy, a, b, adx, ady, d, dn, dp, span;
        coord_t px, py;
        ddx = int'(x1) - int'(x0);
        ddy = int'(y1) - int'(y0);
        a   = int'(y0) - int'(y1);
        b   = ddx;
        adx = (ddx < 0) ? -ddx : ddx;
        ady = (ddy < 0) ? -ddy : ddy;
        px  = x0;
        py  = y0;
        if ((ddx >= 0 && ddy < 0) || (ddx <= 0 && ddy > 0)) begin
            // falling: walk with x up and y down
            if (ddx <= 0 && ddy > 0) begin
                a  = -a;
                b  = -b;
                px = x1;
                py = y1;
            end
            if (adx >= ady) begin
                span = adx;
                dirs = make_dirs(1, 0, 1, -1);
                d    = 2 * a - b;
                dn   = 2 * a;
                dp   = 2 * (a - b);
            end else begin
                span = ady;
                dirs = make_dirs(1, -1, 0, -1);
                d    = a - 2 * b;
                dp   = -(2 * b);
                dn   = 2 * (a - b);
            end
        end else begin
            // rising: walk with x up and y up
            if (ddx <= 0 && ddy <= 0) begin
                a  = -a;
                b  = -b;
                px = x1;
                py = y1;
            end
            if (adx >= ady) begin
                span = adx;
                dirs = make_dirs(1, 1, 1, 0);
                d    = 2 * a + b;
                dp   = 2 * a;
                dn   = 2 * (a + b);
            end else begin
                span = ady;
                dirs = make_dirs(0, 1, 1, 1);
                d    = 2 * b + a;
                dn   = 2 * b;
                dp   = 2 * (a + b);
            end
        end
        cur_x       = px;
        cur_y       = py;
        decision    = dec_t'(d);
        inc_neg     = dec_t'(dn);
        inc_pos     = dec_t'(dp);
        steps_left  = count_t'(span);
        line_active = (steps_left != '0);
    endtask

    // Advance one pixel; a tie on the decision takes the nonnegative step
    task automatic advance_line();
        if (decision < 0) begin
            cur_x    = cur_x + coord_t'(dirs.neg_dx);
            cur_y    = cur_y + coord_t'(dirs.neg_dy);
            decision = decision + inc_neg;
        end else begin
            cur_x    = cur_x + coord_t'(dirs.pos_dx);
            cur_y    = cur_y + coord_t'(dirs.pos_dy);
            decision = decision + inc_pos;
        end
        steps_left = steps_left - count_t'(1);
        if (steps_left == '0) begin
            line_active = 1'b0;
        end
    endtask

    // Predict the pixel, if any, that one accepted request produces
    task automatic rasterize_request(input logic op, input coord_t x0, input coord_t y0,
                                     input coord_t x1, input coord_t y1);
        if (op == OP_START) begin
            begin_line(x0, y0, x1, y1);
        end else if (line_active) begin
            advance_line();
        end else begin
            // step with no line in progress: dropped without a pixel
            return;
        end
        expected_pixels.push_back('{x: cur_x, y: cur_y, last_pixel: !line_active});
    endtask

    task automatic check_pixel();
        pixel_t want;
        if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("pixel (%0d,%0d) with none expected",
                                      i_pixel_x, i_pixel_y));
            return;
        end
        want = expected_pixels.pop_front();
        if (i_pixel_x !== want.x) begin
            report_mismatch($sformatf("pixel_x got %0d want %0d", i_pixel_x, want.x));
        end
        if (i_pixel_y !== want.y) begin
            report_mismatch($sformatf("pixel_y got %0d want %0d", i_pixel_y, want.y));
        end
        if (i_last_pixel !== want.last_pixel) begin
            report_mismatch($sformatf("last_pixel got %b want %b at (%0d,%0d)",
                                      i_last_pixel, want.last_pixel, want.x, want.y));
        end
    endtask

    // Retire the output first: it always belongs to an older request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_x         = '0;
            cur_y         = '0;
            decision      = '0;
            inc_neg       = '0;
            inc_pos       = '0;
            dirs          = '0;
            steps_left    = '0;
            line_active   = 1'b0;
            o_error_count = 0;
            expected_pixels.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_pixel();
            end
            if (i_in_valid && i_in_ready) begin
                rasterize_request(i_opcode, i_x_start, i_y_start, i_x_end, i_y_end);
            end
        end
        o_pending_count = expected_pixels.size();
    end

endmodule

[dv/midpoint_line_rasterizer_tb.sv]
`timescale 1ns / 1ps
module midpoint_line_rasterizer_tb;
    import mlr_pkg::*;

    localparam int COORD_BITS = 12;
    localparam int MIN_COORD  = -(1 << (COORD_BITS - 1));
    localparam int MAX_COORD  = (1 << (COORD_BITS - 1)) - 1;
    localparam int ITEM_GOAL  = 650;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_ready;
    logic   i_opcode;
    coord_t i_x_start;
    coord_t i_y_start;
    coord_t i_x_end;
    coord_t i_y_end;
    logic   o_out_valid;
    logic   i_out_ready;
    coord_t o_pixel_x;
    coord_t o_pixel_y;
    logic   o_last_pixel;

    int error_count;
    int pending_count;

    // Sender pacing and bookkeeping of useful requests
    bit gaps_on;
    int burst_left;
    int n_items;
    int line_left;
    bit hold_off_req;

    midpoint_line_rasterizer #(
        .COORD_BITS(COORD_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_x_start   (i_x_start),
        .i_y_start   (i_y_start),
        .i_x_end     (i_x_end),
        .i_y_end     (i_y_end),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_last_pixel(o_last_pixel)
    );

    midpoint_line_checker #(
        .COORD_BITS(COORD_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_x_start      (i_x_start),
        .i_y_start      (i_y_start),
        .i_x_end        (i_x_end),
        .i_y_end        (i_y_end),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_pixel_x      (o_pixel_x),
        .i_pixel_y      (o_pixel_y),
        .i_last_pixel   (o_last_pixel),
        .o_error_count  (error_count),
        .o_pending_count(pending_count)
    );

    // Clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Abort a hung run
    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

    // Receiver: stall in changing patterns, hold off for a long stretch on request
    initial begin
        int unsigned cyc;
        int unsigned mode;
        int unsigned hold_left;
        i_out_ready = 1'b0;
        cyc         = 0;
        mode        = 0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = 300;
            end
            if (cyc % 64 == 0) begin
                mode = $urandom_range(0, 3);
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else begin
                case (mode)
                    0: begin
                        i_out_ready = 1'b1;
                    end
                    1: begin
                        i_out_ready = ($urandom_range(0, 9) < 7);
                    end
                    2: begin
                        i_out_ready = ($urandom_range(0, 9) < 3);
                    end
                    default: begin
                        i_out_ready = (cyc[1:0] != 2'b11);
                    end
                endcase
            end
        end
    end

    // Offer one request at a falling edge and hold it until taken
    task automatic send_request(input logic op, input int xs, input int ys,
                                input int xe, input int ye);
        if (gaps_on && burst_left == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left != 0) begin
            burst_left--;
        end
        i_in_valid = 1'b1;
        i_opcode   = op;
        i_x_start  = coord_t'(xs);
        i_y_start  = coord_t'(ys);
        i_x_end    = coord_t'(xe);
        i_y_end    = coord_t'(ye);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Step request with junk endpoints; only counted while a line is running
    task automatic send_step();
        send_request(OP_STEP, $urandom, $urandom, $urandom, $urandom);
        if (line_left != 0) begin
            line_left--;
            n_items++;
        end
    endtask

    task automatic draw_line(input int x0, input int y0, input int x1, input int y1,
                             input int n_steps);
        int adx, ady;
        adx = (x1 > x0) ? x1 - x0 : x0 - x1;
        ady = (y1 > y0) ? y1 - y0 : y0 - y1;
        send_request(OP_START, x0, y0, x1, y1);
        n_items++;
        line_left = (adx > ady) ? adx : ady;
        repeat (n_steps) send_step();
    endtask

    // Offset an endpoint, mirroring the offset if it would leave the range
    function automatic int pick_end(input int origin, input int delta);
        int v;
        v = origin + delta;
        if (v > MAX_COORD || v < MIN_COORD) begin
            v = origin - delta;
        end
        return v;
    endfunction

    // Stimulus
    initial begin
        int  kind, lim, dx, dy, span, n_steps;
        int  x0, y0, x1, y1;
        bit  held, paused;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_opcode     = OP_START;
        i_x_start    = '0;
        i_y_start    = '0;
        i_x_end      = '0;
        i_y_end      = '0;
        gaps_on      = 1'b1;
        burst_left   = 0;
        n_items      = 0;
        line_left    = 0;
        hold_off_req = 1'b0;
        held         = 1'b0;
        paused       = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: single-pixel line, idle step, range extremes, restart, tie, octants
        draw_line(0, 0, 0, 0, 0);
        send_step();
        draw_line(MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD, 2);
        draw_line(MAX_COORD, MIN_COORD, MIN_COORD, MAX_COORD, 2);
        draw_line(0, 0, 2, 1, 3);
        draw_line(5, 5, 4, 8, 3);
        draw_line(-3, -1, -7, -4, 4);
        draw_line(10, -10, 10, -13, 3);

        // Random lines, mostly complete, some broken off or overrun
        while (n_items < ITEM_GOAL) begin
            kind = $urandom_range(0, 99);
            x0   = $urandom_range(0, 4095);
            x0   = x0 + MIN_COORD;
            y0   = $urandom_range(0, 4095);
            y0   = y0 + MIN_COORD;
            lim  = ($urandom_range(0, 7) == 0) ? 60 : 12;
            dx   = $urandom_range(0, 2 * lim);
            dx   = dx - lim;
            dy   = $urandom_range(0, 2 * lim);
            dy   = dy - lim;
            if (kind >= 65 && kind < 78) begin
                // axis-aligned or single-point lines
                case ($urandom_range(0, 2))
                    0: dx = 0;
                    1: dy = 0;
                    default: begin
                        dx = 0;
                        dy = 0;
                    end
                endcase
            end
            x1   = pick_end(x0, dx);
            y1   = pick_end(y0, dy);
            span = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ?
                   (dx < 0 ? -dx : dx) : (dy < 0 ? -dy : dy);
            n_steps = span + $urandom_range(0, 2);
            if ($urandom_range(0, 9) == 0) begin
                n_steps = $urandom_range(0, span);
            end
            if (kind < 78) begin
                draw_line(x0, y0, x1, y1, n_steps);
            end else if (kind < 88) begin
                // long line across the plane, abandoned early
                x1 = $urandom_range(0, 4095);
                x1 = x1 + MIN_COORD;
                y1 = $urandom_range(0, 4095);
                y1 = y1 + MIN_COORD;
                draw_line(x0, y0, x1, y1, $urandom_range(3, 30));
            end else if (kind < 94) begin
                gaps_on = 1'b0;
                draw_line(x0, y0, x1, y1, n_steps);
                gaps_on = 1'b1;
            end else begin
                repeat ($urandom_range(1, 3)) send_step();
            end

            // Hold the receiver off while the sender keeps pushing
            if (!held && n_items >= 200) begin
                held         = 1'b1;
                hold_off_req = 1'b1;
                gaps_on      = 1'b0;
                draw_line(x0, y0, pick_end(x0, 25), pick_end(y0, -9), 25);
                gaps_on      = 1'b1;
            end
            // Let the pipeline drain completely before going on
            if (!paused && n_items >= 420) begin
                paused     = 1'b1;
                i_in_valid = 1'b0;
                while (pending_count != 0) @(negedge i_clk);
            end
        end
        i_in_valid = 1'b0;

        // Drain, then allow stray pixels to show up
        while (pending_count != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/mlr_pkg.sv
design/mlr_setup.sv
design/mlr_step.sv
design/midpoint_line_rasterizer.sv
dv/midpoint_line_checker.sv
dv/midpoint_line_rasterizer_tb.sv
